[src/tle_pkg.sv]
// Shared types and character codes for the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

  localparam int CNT_W      = 6;
  localparam int OUT_DATA_W = 24;

  localparam logic [7:0] CHR_BEL    = 8'h07;
  localparam logic [7:0] CHR_BS     = 8'h08;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_ESC    = 8'h1B;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;

  typedef logic [1:0] chan_t;
  localparam chan_t CH_ECHO = 2'd0;
  localparam chan_t CH_LINE = 2'd1;
  localparam chan_t CH_END  = 2'd2;

  typedef enum logic [2:0] {
    CMD_ESC    = 3'd0,
    CMD_RUBOUT = 3'd1,
    CMD_BELL   = 3'd2,
    CMD_CHAR   = 3'd3,
    CMD_LINE   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic             emit;
    logic             ovf;
    logic [CNT_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    chan_t            channel;
    logic [7:0]       char_value;
    logic [CNT_W-1:0] line_length;
    logic             by_overflow;
    logic             last;
  } result_t;

endpackage

[src/tle_front.sv]
// Front end: accept received bytes, track the fill count, queue commands.
`timescale 1ns / 1ps

module tle_front #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                q_push,
  output tle_pkg::cmd_t       q_cmd,
  output tle_pkg::store_wr_t  st_wr,
  input  logic                line_done
);
  import tle_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LINE_CAPACITY - 1);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] fill_inc;
  logic             busy_r, busy_nxt;
  logic             accept;

  // hold input while a completed line is still being sent out or the queue is full
  assign in_ready = !busy_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign fill_inc = fill_r + 1'b1;

  always_comb begin
    fill_nxt   = fill_r;
    busy_nxt   = busy_r && !line_done;
    q_push     = 1'b0;
    q_cmd      = '{kind: CMD_CHAR, data: in_byte, emit: 1'b0, ovf: 1'b0, len: '0};
    st_wr      = '{en: 1'b0, addr: fill_r, data: in_byte};
    if (accept) begin
      unique case (in_byte)
        CHR_ESC: begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_ESC;
          fill_nxt   = '0;
        end
        CHR_LF: begin
          q_push = 1'b0;
        end
        CHR_BS: begin
          q_push = 1'b1;
          if (fill_r != '0) begin
            q_cmd.kind = CMD_RUBOUT;
            fill_nxt   = fill_r - 1'b1;
          end else begin
            q_cmd.kind = CMD_BELL;
          end
        end
        CHR_CR: begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_LINE;
          q_cmd.emit = 1'b1;
          q_cmd.len  = fill_r;
          fill_nxt   = '0;
          busy_nxt   = 1'b1;
        end
        default: begin
          st_wr.en   = 1'b1;
          q_push     = 1'b1;
          q_cmd.kind = CMD_CHAR;
          if (fill_inc == FULL_COUNT) begin
            q_cmd.emit = 1'b1;
            q_cmd.ovf  = 1'b1;
            q_cmd.len  = fill_inc;
            fill_nxt   = '0;
            busy_nxt   = 1'b1;
          end else begin
            fill_nxt = fill_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      busy_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

[src/tle_cmd_fifo.sv]
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module tle_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tle_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output tle_pkg::cmd_t dout,
  output logic          empty
);
  import tle_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

[src/tle_back.sv]
// Back end: line store and result sequencer with an output register.
`timescale 1ns / 1ps

module tle_back #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  tle_pkg::cmd_t      q_cmd,
  input  tle_pkg::store_wr_t st_wr,
  output tle_pkg::result_t   res,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               line_done
);
  import tle_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ECHO = 4'b0010,
    S_LINE = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [1:0]       last_step;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  result_t          out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             advance;
  logic [7:0]       rd_data_r;
  logic [7:0]       line_store [LINE_CAPACITY];

  function automatic logic [7:0] echo_char(cmd_kind_t k, logic [7:0] d, logic [1:0] s);
    logic [7:0] c;
    case (k) inside
      CMD_ESC:    c = (s == 2'd0) ? CHR_BSLASH : ((s == 2'd1) ? CHR_CR : CHR_LF);
      CMD_RUBOUT: c = (s == 2'd1) ? CHR_SPACE : CHR_BS;
      CMD_BELL:   c = CHR_BEL;
      default:    c = d;
    endcase
    return c;
  endfunction

  always_comb begin
    case (cmd_r.kind) inside
      CMD_ESC, CMD_RUBOUT: last_step = 2'd2;
      default:             last_step = 2'd0;
    endcase
  end

  assign advance   = !out_valid_r || res_ready;
  assign res       = out_r;
  assign res_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_ready;
    q_pop         = 1'b0;
    line_done     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          step_nxt = 2'd0;
          idx_nxt  = '0;
          if (q_cmd.kind == CMD_LINE) state_nxt = (q_cmd.len == '0) ? S_END : S_LINE;
          else                        state_nxt = S_ECHO;
        end
      end
      S_ECHO: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{channel: CH_ECHO,
                      char_value: echo_char(cmd_r.kind, cmd_r.data, step_r),
                      line_length: '0, by_overflow: 1'b0,
                      last: !cmd_r.emit && (step_r == last_step)};
          if (step_r == last_step) state_nxt = cmd_r.emit ? S_LINE : S_IDLE;
          else                     step_nxt  = step_r + 1'b1;
        end
      end
      S_LINE: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{channel: CH_LINE, char_value: rd_data_r,
                      line_length: '0, by_overflow: 1'b0, last: 1'b0};
          idx_nxt = idx_r + 1'b1;
          if (idx_nxt == cmd_r.len) state_nxt = S_END;
        end
      end
      S_END: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{channel: CH_END, char_value: 8'd0,
                      line_length: cmd_r.len, by_overflow: cmd_r.ovf, last: 1'b1};
          line_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // read ahead at the next index so the character is ready when it is sent
  always_ff @(posedge clk) begin
    if (st_wr.en) line_store[st_wr.addr[AW-1:0]] <= st_wr.data;
    rd_data_r <= line_store[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/terminal_line_editor_core.sv]
// Top level of the terminal line editor: front end, command queue, back end.
// Each byte's command passes the queue and the sequencer to the output register.
// Throughput: the back end takes a command when idle, then sends one result word per
//   cycle unless stalled (0, 1 or 3 echoes, N line characters, one end marker); up to
//   two echo-only bytes queue ahead, input holds while a completed line goes out.
// Reset: clears the fill count, queue, sequencer and output valid; the line store
//   is not cleared.
`timescale 1ns / 1ps

module terminal_line_editor_core #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] channel, [9:2] char_value, [15:10] line_length, [16] by_overflow, rest zero
  output logic [tle_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import tle_pkg::*;

  logic      q_full, q_empty, q_push, q_pop, line_done;
  cmd_t      q_din, q_dout;
  store_wr_t st_wr;
  result_t   res;

  // classify each byte, update the fill count, write the store
  tle_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_din),
    .st_wr     (st_wr),
    .line_done (line_done)
  );

  // decouple classification from result generation
  tle_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // sequence echo characters, line characters and the end marker
  tle_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (q_dout),
    .st_wr     (st_wr),
    .res       (res),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .line_done (line_done)
  );

  // pack the result word, first field lowest
  assign out_tdata = OUT_DATA_W'({res.by_overflow, res.line_length, res.char_value,
                                  res.channel});
  assign out_tlast = res.last;

endmodule

[src/tle_checker.sv]
// Port-level checks for the terminal line editor and their bind.
`timescale 1ns / 1ps

module tle_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tle_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import tle_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // end marker always closes the results of a byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == CH_END |-> out_tlast)
    else $error("end marker without last");

  // a line character is never the last result of a byte
  a_line_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == CH_LINE |-> !out_tlast)
    else $error("line character marked last");

  // only the end marker carries length and overflow; no unknown channel
  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3 &&
      (out_tdata[1:0] == CH_END || out_tdata[16:10] == 7'd0) &&
      out_tdata[OUT_DATA_W-1:17] == '0)
    else $error("malformed result word");

endmodule

bind terminal_line_editor_core tle_checker u_tle_checker (.*);

[verif/terminal_line_editor_checker.sv]
// Scoreboard for the terminal line editor: predicts result words and compares them.
`timescale 1ns / 1ps

module terminal_line_editor_checker
  import tle_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_cnt,
  output int                    pending_cnt
);

  logic [7:0]       line_chars [LINE_CAPACITY];
  logic [CNT_W-1:0] line_fill;
  result_t          expected_words [$];
  result_t          byte_words [$];

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    line_fill   = '0;
  end

  task automatic add_word(chan_t ch, logic [7:0] chr, logic [CNT_W-1:0] len, logic ovf);
    result_t w;
    w.channel     = ch;
    w.char_value  = chr;
    w.line_length = len;
    w.by_overflow = ovf;
    w.last        = 1'b0;
    byte_words.push_back(w);
  endtask

  // Flush the held line as line characters plus the end marker, then start a new line.
  task automatic add_completed_line(logic ovf);
    for (int i = 0; i < int'(line_fill); i++)
      add_word(CH_LINE, line_chars[i], '0, 1'b0);
    add_word(CH_END, 8'h00, line_fill, ovf);
    line_fill = '0;
  endtask

  task automatic edit_with_byte(logic [7:0] rx);
    byte_words.delete();
    if (rx == CHR_ESC) begin
      add_word(CH_ECHO, CHR_BSLASH, '0, 1'b0);
      add_word(CH_ECHO, CHR_CR, '0, 1'b0);
      add_word(CH_ECHO, CHR_LF, '0, 1'b0);
      line_fill = '0;
    end else if (rx == CHR_LF) begin
      // swallowed, nothing to echo
    end else if (rx == CHR_BS) begin
      if (line_fill != 0) begin
        line_fill = line_fill - 1'b1;
        add_word(CH_ECHO, CHR_BS, '0, 1'b0);
        add_word(CH_ECHO, CHR_SPACE, '0, 1'b0);
        add_word(CH_ECHO, CHR_BS, '0, 1'b0);
      end else begin
        add_word(CH_ECHO, CHR_BEL, '0, 1'b0);
      end
    end else if (rx == CHR_CR) begin
      add_completed_line(1'b0);
    end else begin
      if (int'(line_fill) < LINE_CAPACITY) begin
        line_chars[line_fill] = rx;
        line_fill = line_fill + 1'b1;
      end
      add_word(CH_ECHO, rx, '0, 1'b0);
      if (int'(line_fill) >= LINE_CAPACITY - 1)
        add_completed_line(1'b1);
    end
    if (byte_words.size() > 0)
      byte_words[byte_words.size()-1].last = 1'b1;
    foreach (byte_words[i])
      expected_words.push_back(byte_words[i]);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: channel %0d char %0d length %0d",
             got.channel, got.char_value, got.line_length);
      fail_cnt++;
    end else begin
      want = expected_words.pop_front();
      compare_field("channel", want.channel, got.channel);
      compare_field("char_value", want.char_value, got.char_value);
      compare_field("line_length", want.line_length, got.line_length);
      compare_field("by_overflow", want.by_overflow, got.by_overflow);
      compare_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_fill = '0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_word('{channel:     out_tdata[1:0],
                     char_value:  out_tdata[9:2],
                     line_length: out_tdata[15:10],
                     by_overflow: out_tdata[16],
                     last:        out_tlast});
      if (in_tvalid && in_tready)
        edit_with_byte(in_tdata);
    end
    pending_cnt = expected_words.size();
  end

endmodule

[verif/terminal_line_editor_core_tb.sv]
// Testbench top for the terminal line editor: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module terminal_line_editor_core_tb;
  import tle_pkg::*;

  localparam int LINE_CAP     = 32;
  localparam int BYTE_TARGET  = 320;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 10;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int fail_cnt;
  int pending_cnt;
  int bytes_sent = 0;
  int ready_hold = 0;
  int cycle_cnt  = 0;
  bit calm       = 1'b0;  // set to run both sides without any gaps

  terminal_line_editor_core #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  terminal_line_editor_checker #(
    .LINE_CAPACITY(LINE_CAP)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_cnt   (fail_cnt),
    .pending_cnt(pending_cnt)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none, often a few cycles, now and then a long stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm)
      return 0;
    if (roll < 65)
      return 0;
    if (roll < 95)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Content of a typed line: mostly printable text, some raw bytes, edits and noise.
  function automatic logic [7:0] typed_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75)
      return 8'($urandom_range(8'h20, 8'h7E));
    if (roll < 85)
      return 8'($urandom_range(0, 255));
    if (roll < 93)
      return CHR_BS;
    if (roll < 96)
      return CHR_ESC;
    return CHR_LF;
  endfunction

  // Drop valid only when a gap comes, so valid never falls and rises in one step.
  task automatic send_byte(logic [7:0] rx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the input quiet until the checker has seen every predicted word.
  task automatic wait_all_words();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Output side: stall at random, independent of what the block is sending.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int line_len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening checks: bell on an empty line, escape, swallowed line feed,
    // empty carriage return, zero and all-ones bytes kept as text, rubout.
    send_byte(CHR_BS);
    send_byte(CHR_ESC);
    send_byte(CHR_LF);
    send_byte(CHR_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(CHR_BS);
    send_byte(8'h42);
    send_byte(CHR_CR);
    send_byte(8'h43);
    send_byte(CHR_ESC);
    send_byte(CHR_CR);

    // Let the output fully drain once before the random part.
    wait_all_words();

    // Random lines: mostly short, some long enough to fill the store and
    // force an overflow flush; a few lines end without a carriage return.
    while (bytes_sent < BYTE_TARGET) begin
      calm = (bytes_sent > 150 && bytes_sent < 200);
      line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
      repeat (line_len) send_byte(typed_byte());
      if ($urandom_range(0, 9) != 0)
        send_byte(CHR_CR);
    end
    calm = 1'b0;

    wait_all_words();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
